@@ sv/iss_pkg.sv @@
// ----------------------------------------------------------------------------
// iss_pkg
// Shared constants and controller/datapath interface types for the
// integer sequence sorter.
// ----------------------------------------------------------------------------
package iss_pkg;

   localparam int MAX_ITEMS = 64;
   localparam int KEY_W     = 32;
   localparam int IDX_W     = $clog2(MAX_ITEMS);
   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

   // key store write selection
   localparam logic [2:0] WR_NONE     = 3'd0;
   localparam logic [2:0] WR_DIRECT   = 3'd1;
   localparam logic [2:0] WR_SHIFT    = 3'd2;
   localparam logic [2:0] WR_KEY_UP   = 3'd3;
   localparam logic [2:0] WR_KEY_ZERO = 3'd4;

   typedef struct packed {
      logic       load;
      logic       step;
      logic [2:0] wr_op;
      logic       count_inc;
      logic       set_ovf;
      logic       emit;
      logic       clear;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic count_full;
      logic key_less;
      logic idx_zero;
      logic last_pending;
      logic emit_end;
   } status_type;

endpackage

@@ sv/iss_ram.sv @@
// ----------------------------------------------------------------------------
// iss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module iss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/iss_ctrl.sv @@
// ----------------------------------------------------------------------------
// iss_ctrl
// Sequencer: accepts keys, runs the insertion shift through the key store
// and steps the sorted read-out.
// ----------------------------------------------------------------------------
module iss_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               req_last_item,
   input  iss_pkg::status_type status,
   output iss_pkg::cmd_type    cmd,
   output logic               busy
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SHIFT = 2'd1;
   localparam logic [1:0] ST_PLACE = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      cmd           = '0;
      cmd.wr_op     = iss_pkg::WR_NONE;
      state_in      = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (status.count_full) begin
                  cmd.set_ovf = 1'b1;
                  if (req_last_item) state_in = ST_EMIT;
               end else if (status.count_zero) begin
                  cmd.wr_op     = iss_pkg::WR_DIRECT;
                  cmd.count_inc = 1'b1;
                  if (req_last_item) state_in = ST_EMIT;
               end else begin
                  cmd.load = 1'b1;
                  state_in = ST_SHIFT;
               end
            end
         end
         ST_SHIFT: begin
            if (status.key_less) begin
               // move the larger key up one slot
               cmd.wr_op = iss_pkg::WR_SHIFT;
               if (status.idx_zero) begin
                  state_in = ST_PLACE;
               end else begin
                  cmd.step = 1'b1;
               end
            end else begin
               cmd.wr_op     = iss_pkg::WR_KEY_UP;
               cmd.count_inc = 1'b1;
               state_in      = status.last_pending ? ST_EMIT : ST_IDLE;
            end
         end
         ST_PLACE: begin
            cmd.wr_op     = iss_pkg::WR_KEY_ZERO;
            cmd.count_inc = 1'b1;
            state_in      = status.last_pending ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (status.emit_end) begin
               cmd.clear = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

@@ sv/iss_datapath.sv @@
// ----------------------------------------------------------------------------
// iss_datapath
// Key store, fill count, shift index, read-out index and result registers.
// ----------------------------------------------------------------------------
module iss_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [iss_pkg::KEY_W-1:0]     req_value,
   input  logic                          req_last_item,
   input  iss_pkg::cmd_type              cmd,
   output iss_pkg::status_type           status,
   output logic                          rsp_strobe,
   output logic [iss_pkg::KEY_W-1:0]     rsp_sorted_value,
   output logic                          rsp_last_result,
   output logic                          rsp_overflowed
);

   logic [iss_pkg::CNT_W-1:0] count_ff;
   logic [iss_pkg::CNT_W-1:0] count_in;
   logic [iss_pkg::CNT_W-1:0] count_m1;
   logic [iss_pkg::IDX_W-1:0] idx_ff;
   logic [iss_pkg::IDX_W-1:0] idx_in;
   logic [iss_pkg::IDX_W-1:0] idx_m1;
   logic [iss_pkg::IDX_W-1:0] emit_ff;
   logic [iss_pkg::IDX_W-1:0] emit_in;
   logic                      ovf_ff;
   logic                      ovf_in;
   logic [iss_pkg::KEY_W-1:0] key_ff;
   logic [iss_pkg::KEY_W-1:0] key_in;
   logic                      last_ff;
   logic                      last_in;
   logic                      strobe_ff;
   logic                      rlast_ff;
   logic                      rovf_ff;

   logic                      wr_en;
   logic [iss_pkg::IDX_W-1:0] wr_addr;
   logic [iss_pkg::KEY_W-1:0] wr_data;
   logic [iss_pkg::IDX_W-1:0] rd_addr;
   logic [iss_pkg::KEY_W-1:0] rd_data;

   assign count_m1 = count_ff - iss_pkg::CNT_W'(1);
   assign idx_m1   = idx_ff - iss_pkg::IDX_W'(1);

   iss_ram #(
      .WIDTH (iss_pkg::KEY_W),
      .DEPTH (iss_pkg::MAX_ITEMS)
   ) u_key_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      wr_en   = (cmd.wr_op != iss_pkg::WR_NONE);
      wr_addr = '0;
      wr_data = key_ff;
      case (cmd.wr_op)
         iss_pkg::WR_DIRECT: begin
            wr_data = req_value;
         end
         iss_pkg::WR_SHIFT: begin
            wr_addr = idx_ff + iss_pkg::IDX_W'(1);
            wr_data = rd_data;
         end
         iss_pkg::WR_KEY_UP: begin
            wr_addr = idx_ff + iss_pkg::IDX_W'(1);
         end
         default: begin
            wr_addr = '0;
         end
      endcase

      if (cmd.load) begin
         rd_addr = count_m1[iss_pkg::IDX_W-1:0];
      end else if (cmd.step) begin
         rd_addr = idx_m1;
      end else begin
         rd_addr = emit_ff;
      end
   end

   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      emit_in  = emit_ff;
      idx_in   = idx_ff;
      key_in   = key_ff;
      last_in  = last_ff;
      if (cmd.load) begin
         key_in  = req_value;
         last_in = req_last_item;
         idx_in  = count_m1[iss_pkg::IDX_W-1:0];
      end
      if (cmd.step) idx_in = idx_m1;
      if (cmd.count_inc) count_in = count_ff + iss_pkg::CNT_W'(1);
      if (cmd.set_ovf) ovf_in = 1'b1;
      if (cmd.emit) emit_in = emit_ff + iss_pkg::IDX_W'(1);
      if (cmd.clear) begin
         count_in = '0;
         ovf_in   = 1'b0;
         emit_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         ovf_ff    <= 1'b0;
         emit_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         ovf_ff    <= ovf_in;
         emit_ff   <= emit_in;
         strobe_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      key_ff   <= key_in;
      last_ff  <= last_in;
      rlast_ff <= cmd.emit && status.emit_end;
      rovf_ff  <= ovf_ff;
   end

   always_comb begin
      status.count_zero   = (count_ff == '0);
      status.count_full   = (count_ff == iss_pkg::CNT_W'(iss_pkg::MAX_ITEMS));
      status.key_less     = ($signed(key_ff) < $signed(rd_data));
      status.idx_zero     = (idx_ff == '0);
      status.last_pending = last_ff;
      status.emit_end     = ((iss_pkg::CNT_W'(emit_ff) + iss_pkg::CNT_W'(1)) == count_ff);
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_sorted_value = rd_data;
   assign rsp_last_result  = rlast_ff;
   assign rsp_overflowed   = rovf_ff;

endmodule

@@ sv/integer_sequence_sorter.sv @@
// ----------------------------------------------------------------------------
// integer_sequence_sorter
// Collects signed 32-bit keys and returns the set in ascending order.
// ----------------------------------------------------------------------------
// Keys are insertion-sorted into a 64-entry key store as they arrive, so the
// store is always in order. The first key of a set, or a key dropped because
// the store is full, is handled in the idle state without a shift; any other
// key is compared with the stored keys from the top down, and each stored key
// greater than it moves up one slot through the single write port of the key
// store, one key per cycle. After the item marked last, busy stays high while
// the set is read out: one result per cycle, each from the registered read
// data of the key store, shown for exactly one cycle with rsp_strobe high and
// taken at the end of that cycle, with no way to stall it. busy falls as the
// final result is shown. The final result carries rsp_last_result; every
// result of a set carries rsp_overflowed if any key of that set was dropped.
// ----------------------------------------------------------------------------
module integer_sequence_sorter (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [iss_pkg::KEY_W-1:0] req_value,
   input  logic                      req_last_item,
   output logic                      rsp_strobe,
   output logic [iss_pkg::KEY_W-1:0] rsp_sorted_value,
   output logic                      rsp_last_result,
   output logic                      rsp_overflowed
);

   iss_pkg::cmd_type    cmd;
   iss_pkg::status_type status;

   iss_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_last_item (req_last_item),
      .status        (status),
      .cmd           (cmd),
      .busy          (busy)
   );

   iss_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_value        (req_value),
      .req_last_item    (req_last_item),
      .cmd              (cmd),
      .status           (status),
      .rsp_strobe       (rsp_strobe),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_result  (rsp_last_result),
      .rsp_overflowed   (rsp_overflowed)
   );

   // more results of the set to come: still reading out
   a_readout_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_result |-> busy)
      else $error("result stream paused mid-set");

   // no result directly follows the final result of a set
   a_final_gap : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_result |=> !rsp_strobe)
      else $error("result after final transfer");

   // a non-final key causes no result
   a_no_early_result : assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_last_item |=> !rsp_strobe)
      else $error("result without final key");

   // the final mark comes only with a strobed result
   a_flag_in_set : assert property (@(posedge clock) disable iff (reset)
      rsp_last_result |-> rsp_strobe)
      else $error("final mark without transfer");

endmodule

@@ tb/tb_integer_sequence_sorter.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_integer_sequence_sorter
// Self-checking bench for the integer sequence sorter.
// ----------------------------------------------------------------------------
// Keys are sent as sets, the final key of each set marked. A short table of
// directed keys (extremes, duplicates, ordered and reversed runs) comes first,
// then random sets of mostly small sizes with a full set and an overflowing
// set among them. Sorted bench-side copies, or typed rows for single-key sets,
// give the expected results, checked field by field with every strobed result.
// ----------------------------------------------------------------------------
module tb_integer_sequence_sorter;

   localparam int DIRECTED_ROWS = 24;
   localparam int RANDOM_ITEMS  = 140;
   localparam int TAIL_CYCLES   = 2 * iss_pkg::MAX_ITEMS + 16;
   localparam int REPORT_LIMIT  = 10;

   typedef logic signed [iss_pkg::KEY_W-1:0] key_type;

   typedef struct packed {
      key_type key;
      logic    last;
      logic    ovf;
   } sorted_key_type;

   typedef struct packed {
      logic [iss_pkg::KEY_W-1:0] value;
      logic                      last;
      logic                      typed;
      logic [iss_pkg::KEY_W-1:0] exp_key;
      logic                      exp_last;
      logic                      exp_ovf;
   } stim_row_type;

   // single-key sets carry their expected result, the rest are predicted
   stim_row_type directed_rows [0:DIRECTED_ROWS-1] = '{
      '{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000, 1'b1, 1'b0},
      '{32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b1, 1'b0},
      '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 1'b1, 1'b0},
      '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0},
      '{32'h0000_0005, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{32'hFFFF_FFFD, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{32'h0000_0005, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{32'h8000_0000, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{32'h0000_0000, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
      '{32'h0000_0004, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{32'h0000_0003, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{32'h0000_0002, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{32'h0000_0001, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
      '{32'hFFFF_FFFE, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{32'h0000_0000, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{32'h0000_0001, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
      '{32'h0000_0009, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{32'h0000_0009, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{32'h0000_0009, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
      '{32'h0000_0001, 1'b1, 1'b1, 32'h0000_0001, 1'b1, 1'b0},
      '{32'hAAAA_AAAA, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{32'h5555_5555, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0}
   };

   logic                      clock;
   logic                      reset         = 1'b1;
   logic                      start         = 1'b0;
   logic                      busy;
   logic [iss_pkg::KEY_W-1:0] req_value     = '0;
   logic                      req_last_item = 1'b0;
   logic                      rsp_strobe;
   logic [iss_pkg::KEY_W-1:0] rsp_sorted_value;
   logic                      rsp_last_result;
   logic                      rsp_overflowed;

   key_type        held_keys[$];      // keys of the open set, kept in ascending order
   logic           keys_dropped = 1'b0;
   sorted_key_type pending_sorted[$];
   int             mismatch_count = 0;
   int             burst_left     = 1;

   integer_sequence_sorter DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_value        (req_value),
      .req_last_item    (req_last_item),
      .rsp_strobe       (rsp_strobe),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_result  (rsp_last_result),
      .rsp_overflowed   (rsp_overflowed)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // adds the key unless the open set is full; the final key queues the whole set in order
   function automatic void place_key(input key_type key, input logic last);
      int             pos;
      sorted_key_type item;
      if (held_keys.size() < iss_pkg::MAX_ITEMS) begin
         pos = 0;
         while (pos < held_keys.size() && held_keys[pos] <= key)
            pos++;
         held_keys.insert(pos, key);
      end else begin
         keys_dropped = 1'b1;
      end
      if (last) begin
         foreach (held_keys[i]) begin
            item.key  = held_keys[i];
            item.last = (i == held_keys.size() - 1);
            item.ovf  = keys_dropped;
            pending_sorted.push_back(item);
         end
         held_keys.delete();
         keys_dropped = 1'b0;
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [iss_pkg::KEY_W-1:0] want,
                                  input logic [iss_pkg::KEY_W-1:0] got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t: %s mismatch, expected %h, got %h", $realtime, what, want, got);
   endtask

   // bursts of transfers separated by random gaps, now and then a long burst
   task automatic pace_sender();
      int gap;
      if (burst_left > 0)
         burst_left--;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? 48 : $urandom_range(1, 10);
      end
   endtask

   task automatic transfer_key(input key_type key, input logic last, input logic predict);
      start         <= 1'b1;
      req_value     <= key;
      req_last_item <= last;
      do @(posedge clock); while (busy !== 1'b0);
      if (predict)
         place_key(key, last);
      pace_sender();
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (pending_sorted.size() != 0)
         @(posedge clock);
   endtask

   always @(posedge clock) begin : check_results
      sorted_key_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_sorted.size() == 0) begin
            report_mismatch("unexpected result", '0, rsp_sorted_value);
         end else begin
            want = pending_sorted.pop_front();
            if (rsp_sorted_value !== want.key)
               report_mismatch("sorted_value", want.key, rsp_sorted_value);
            if (rsp_last_result !== want.last)
               report_mismatch("last_result", iss_pkg::KEY_W'(want.last),
                               iss_pkg::KEY_W'(rsp_last_result));
            if (rsp_overflowed !== want.ovf)
               report_mismatch("overflowed", iss_pkg::KEY_W'(want.ovf),
                               iss_pkg::KEY_W'(rsp_overflowed));
         end
      end
   end

   initial begin : stimulus
      stim_row_type   row;
      sorted_key_type typed_result;
      key_type        key;
      key_type        base;
      int             set_len;
      int             set_index;
      int             key_mode;
      int             random_items;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         row = directed_rows[r];
         if (row.typed) begin
            typed_result.key  = row.exp_key;
            typed_result.last = row.exp_last;
            typed_result.ovf  = row.exp_ovf;
            pending_sorted.push_back(typed_result);
         end
         transfer_key(row.value, row.last, !row.typed);
      end
      drain_results();

      set_index    = 0;
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         case (set_index)
            1:       set_len = iss_pkg::MAX_ITEMS;
            3:       set_len = iss_pkg::MAX_ITEMS + 3;   // drops the last key and two before it
            default: set_len = $urandom_range(1, 12);
         endcase
         key_mode = $urandom_range(0, 4);
         base     = $urandom;
         for (int k = 0; k < set_len; k++) begin
            case (key_mode)
               0:       key = $urandom;
               1:       key = $signed($urandom_range(0, 7)) - 4;   // many duplicates
               2:       key = base - k;
               3:       key = base + k;
               default: begin
                  case ($urandom_range(0, 4))
                     0:       key = 32'h8000_0000;
                     1:       key = 32'h7FFF_FFFF;
                     2:       key = '0;
                     3:       key = '1;
                     default: key = $urandom;
                  endcase
               end
            endcase
            transfer_key(key, k == set_len - 1, 1'b1);
         end
         random_items += set_len;
         set_index++;
         if ($urandom_range(0, 4) == 0)
            drain_results();
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_sorted.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
